// ===== sv/temporal_median_background_subtract_defines.svh =====
// Assertion macros shared by the temporal median background subtraction block.
// Each macro expects a clock named clk_i and an active-low reset named rst_ni.
`ifndef TEMPORAL_MEDIAN_BACKGROUND_SUBTRACT_DEFINES_SVH
`define TEMPORAL_MEDIAN_BACKGROUND_SUBTRACT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TMBS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TMBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tmbs_pkg.sv =====
`timescale 1ns / 1ps

package tmbs_pkg;

  // Window length in frames and number of pixel positions per frame.
  localparam int WIN_FRAMES   = 5;
  localparam int FRAME_PIXELS = 307200;

  // Field widths.
  localparam int PIX_W  = 8;
  localparam int IDX_W  = 19;
  localparam int WORD_W = PIX_W * WIN_FRAMES;
  localparam int ADDR_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam int CNT_W  = $clog2(WIN_FRAMES + 1);

  // Upper median: rank N/2 in ascending order.
  localparam int MED_RANK = WIN_FRAMES / 2;

  // Stream data width and padding.
  localparam int DATA_W = 32;
  localparam int PAD_W  = DATA_W - IDX_W - PIX_W;

  // Threshold after reset.
  localparam logic [PIX_W-1:0] THR_RESET = 8'd30;

  // Item leaving the history stage: updated window of one position.
  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [PIX_W-1:0]  pix;
    logic [WORD_W-1:0] word;
  } win_item_t;

  // Item leaving the median stages.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] med;
  } med_item_t;

endpackage

// ===== sv/tmbs_hist.sv =====
`timescale 1ns / 1ps

module tmbs_hist (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic [tmbs_pkg::PIX_W-1:0]        pix_i,
  input  logic [tmbs_pkg::IDX_W-1:0]        idx_i,
  input  logic                              emit_i,
  output logic                              ready_o,
  output logic                              valid_o,
  output tmbs_pkg::win_item_t               item_o,
  input  logic                              ready_i
);

  // Per-position history, newest value in the low byte.
  logic [tmbs_pkg::WORD_W-1:0] hist_mem_q [tmbs_pkg::FRAME_PIXELS];

  logic                          s1_valid_q;
  logic                          s1_emit_q;
  logic [tmbs_pkg::PIX_W-1:0]    s1_pix_q;
  logic [tmbs_pkg::IDX_W-1:0]    s1_idx_q;
  logic [tmbs_pkg::ADDR_W-1:0]   s1_addr_q;
  logic [tmbs_pkg::WORD_W-1:0]   rd_data_q;

  // Most recent write, used to bypass the read that raced with it.
  logic                          lw_valid_q;
  logic [tmbs_pkg::ADDR_W-1:0]   lw_addr_q;
  logic [tmbs_pkg::WORD_W-1:0]   lw_word_q;

  logic                                      load;
  logic                                      leave;
  logic [tmbs_pkg::ADDR_W-1:0]               addr_in;
  logic [tmbs_pkg::WORD_W-1:0]               old_word;
  logic [tmbs_pkg::WORD_W+tmbs_pkg::PIX_W-1:0] shifted;
  logic [tmbs_pkg::WORD_W-1:0]               new_word;

  // Items with no result leave the stage without waiting on downstream.
  assign leave   = s1_valid_q && (!s1_emit_q || ready_i);
  assign ready_o = !s1_valid_q || leave;
  assign load    = valid_i && ready_o;
  assign addr_in = tmbs_pkg::ADDR_W'(idx_i);

  // The item ahead wrote on the edge this item was read; take its word instead.
  always_comb begin
    if (lw_valid_q && (lw_addr_q == s1_addr_q)) begin
      old_word = lw_word_q;
    end else begin
      old_word = rd_data_q;
    end
    shifted  = {old_word, s1_pix_q};
    new_word = shifted[tmbs_pkg::WORD_W-1:0];
  end

  // Stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      lw_valid_q <= 1'b0;
    end else begin
      if (load) begin
        s1_valid_q <= 1'b1;
      end else if (leave) begin
        s1_valid_q <= 1'b0;
      end
      if (leave) begin
        lw_valid_q <= 1'b1;
      end
    end
  end

  // Stage payload and last-write record.
  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_emit_q <= emit_i;
      s1_pix_q  <= pix_i;
      s1_idx_q  <= idx_i;
      s1_addr_q <= addr_in;
    end
    if (leave) begin
      lw_addr_q <= s1_addr_q;
      lw_word_q <= new_word;
    end
  end

  // History memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (leave) begin
      hist_mem_q[s1_addr_q] <= new_word;
    end
    if (load) begin
      rd_data_q <= hist_mem_q[addr_in];
    end
  end

  assign valid_o     = s1_valid_q && s1_emit_q;
  assign item_o.idx  = s1_idx_q;
  assign item_o.pix  = s1_pix_q;
  assign item_o.word = new_word;

endmodule

// ===== sv/tmbs_median.sv =====
`timescale 1ns / 1ps

module tmbs_median (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  tmbs_pkg::win_item_t   item_i,
  output logic                  ready_o,
  output logic                  valid_o,
  output tmbs_pkg::med_item_t   item_o,
  input  logic                  ready_i
);

  localparam int N = tmbs_pkg::WIN_FRAMES;

  logic                 v2_q;
  tmbs_pkg::win_item_t  it2_q;
  logic                 v3_q;
  tmbs_pkg::win_item_t  it3_q;
  logic [N-1:0][N-1:0]  bef3_q;

  logic [N-1:0][N-1:0]                 bef;
  logic [N-1:0][tmbs_pkg::CNT_W-1:0]   rank;
  logic [tmbs_pkg::PIX_W-1:0]          med;
  logic                                rdy2;
  logic                                rdy3;

  assign rdy3    = !v3_q || ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign ready_o = rdy2;

  // Compare every pair; ties are broken by slot so ranks are unique.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        if (j < i) begin
          bef[i][j] = it2_q.word[8*j +: 8] <= it2_q.word[8*i +: 8];
        end else if (j > i) begin
          bef[i][j] = it2_q.word[8*j +: 8] < it2_q.word[8*i +: 8];
        end else begin
          bef[i][j] = 1'b0;
        end
      end
    end
  end

  // Rank each slot and pick the one at the median rank.
  always_comb begin
    med = '0;
    for (int i = 0; i < N; i++) begin
      rank[i] = '0;
      for (int j = 0; j < N; j++) begin
        rank[i] = rank[i] + tmbs_pkg::CNT_W'(bef3_q[i][j]);
      end
      if (rank[i] == tmbs_pkg::CNT_W'(tmbs_pkg::MED_RANK)) begin
        med = med | it3_q.word[8*i +: 8];
      end
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy2) begin
        v2_q <= valid_i;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (rdy2 && valid_i) begin
      it2_q <= item_i;
    end
    if (rdy3 && v2_q) begin
      it3_q  <= it2_q;
      bef3_q <= bef;
    end
  end

  assign valid_o    = v3_q;
  assign item_o.idx = it3_q.idx;
  assign item_o.pix = it3_q.pix;
  assign item_o.med = med;

endmodule

// ===== sv/tmbs_fg.sv =====
`timescale 1ns / 1ps

module tmbs_fg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  tmbs_pkg::med_item_t         item_i,
  input  logic [tmbs_pkg::PIX_W-1:0]  thr_i,
  output logic                        ready_o,
  output logic                        valid_o,
  output logic [tmbs_pkg::PIX_W-1:0]  med_o,
  output logic                        fg_o,
  output logic [tmbs_pkg::IDX_W-1:0]  idx_o,
  input  logic                        ready_i
);

  logic                        out_valid_q;
  logic [tmbs_pkg::PIX_W-1:0]  med_q;
  logic                        fg_q;
  logic [tmbs_pkg::IDX_W-1:0]  idx_q;

  logic [tmbs_pkg::PIX_W-1:0]  diff;
  logic                        fg_d;

  assign ready_o = !out_valid_q || ready_i;

  // Absolute difference against the background and threshold test.
  always_comb begin
    if (item_i.pix > item_i.med) begin
      diff = item_i.pix - item_i.med;
    end else begin
      diff = item_i.med - item_i.pix;
    end
    fg_d = diff > thr_i;
  end

  // Output register valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready_o) begin
      out_valid_q <= valid_i;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      med_q <= item_i.med;
      fg_q  <= fg_d;
      idx_q <= item_i.idx;
    end
  end

  assign valid_o = out_valid_q;
  assign med_o   = med_q;
  assign fg_o    = fg_q;
  assign idx_o   = idx_q;

endmodule

// ===== sv/temporal_median_background_subtract.sv =====
`timescale 1ns / 1ps
// Channel  | Direction | Contents
// s_axis   | in        | tdata: pixel_value, pixel_index; tlast: end_of_frame
// m_axis   | out       | tdata: median_value, out_index; tuser: foreground
// cfg      | in        | fg_threshold, written when cfg_we_i is high
//
// One pixel is accepted per clock while s_axis_tready is high. The history read
// is registered at the accept edge, the read-modify-write feeds the pairwise
// compare stage, the compare results are registered, and rank select with the
// foreground test loads the output register, from which the result is offered.
// The history memory keeps one word per position and gets one read and one
// write per cycle; no clearing pass is made after reset.
// Reset clears the frame count, the valid bits and sets the threshold to 30.
// A stall on m_axis holds the pipeline; bubbles ahead of it are filled first.

`include "temporal_median_background_subtract_defines.svh"

module temporal_median_background_subtract (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [7:0] pixel_value, [26:8] pixel_index, [31:27] zero
  input  logic [tmbs_pkg::DATA_W-1:0]    s_axis_tdata,
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] median_value, [26:8] out_index, [31:27] zero
  output logic [tmbs_pkg::DATA_W-1:0]    m_axis_tdata,
  // [0] foreground
  output logic                           m_axis_tuser,
  input  logic                           cfg_we_i,
  input  logic [tmbs_pkg::PIX_W-1:0]     cfg_wdata_i
);

  logic [tmbs_pkg::PIX_W-1:0]  thr_q;
  logic [tmbs_pkg::CNT_W-1:0]  frames_q;

  logic                        s_acc;
  logic                        in_range;
  logic                        emit;
  logic [tmbs_pkg::PIX_W-1:0]  in_pix;
  logic [tmbs_pkg::IDX_W-1:0]  in_idx;

  logic                        hist_valid;
  tmbs_pkg::win_item_t         hist_item;
  logic                        med_ready;
  logic                        med_valid;
  tmbs_pkg::med_item_t         med_item;
  logic                        fg_ready;
  logic [tmbs_pkg::PIX_W-1:0]  out_med;
  logic                        out_fg;
  logic [tmbs_pkg::IDX_W-1:0]  out_idx;

  assign in_pix   = s_axis_tdata[tmbs_pkg::PIX_W-1:0];
  assign in_idx   = s_axis_tdata[tmbs_pkg::PIX_W +: tmbs_pkg::IDX_W];
  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign in_range = 32'(in_idx) < 32'(tmbs_pkg::FRAME_PIXELS);
  // The current frame completes the window once enough frames have ended.
  assign emit     = frames_q >= tmbs_pkg::CNT_W'(tmbs_pkg::WIN_FRAMES - 1);

  // Threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= tmbs_pkg::THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // Completed-frame count, saturating at the window length.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= '0;
    end else if (s_acc && s_axis_tlast &&
                 (frames_q < tmbs_pkg::CNT_W'(tmbs_pkg::WIN_FRAMES))) begin
      frames_q <= frames_q + 1'b1;
    end
  end

  // Out-of-range positions are accepted and dropped here.
  assign hist_valid = s_axis_tvalid && in_range;

  tmbs_hist u_hist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (hist_valid),
    .pix_i   (in_pix),
    .idx_i   (in_idx),
    .emit_i  (emit),
    .ready_o (s_axis_tready),
    .valid_o (med_valid),
    .item_o  (hist_item),
    .ready_i (med_ready)
  );

  logic med_out_valid;

  tmbs_median u_median (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (med_valid),
    .item_i  (hist_item),
    .ready_o (med_ready),
    .valid_o (med_out_valid),
    .item_o  (med_item),
    .ready_i (fg_ready)
  );

  tmbs_fg u_fg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (med_out_valid),
    .item_i  (med_item),
    .thr_i   (thr_q),
    .ready_o (fg_ready),
    .valid_o (m_axis_tvalid),
    .med_o   (out_med),
    .fg_o    (out_fg),
    .idx_o   (out_idx),
    .ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {{tmbs_pkg::PAD_W{1'b0}}, out_idx, out_med};
  assign m_axis_tuser = out_fg;

  // An empty output register never blocks the input side.
  `TMBS_ASSERT_NOW(a_no_block, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")

  // No result leaves before the window can be full.
  `TMBS_ASSERT_NOW(a_window_full, m_axis_tvalid,
    frames_q >= tmbs_pkg::CNT_W'(tmbs_pkg::WIN_FRAMES - 1), "result before window full")

  // A frame end below saturation advances the count by exactly one.
  `TMBS_ASSERT_NEXT(a_frame_count,
    s_acc && s_axis_tlast && (frames_q < tmbs_pkg::CNT_W'(tmbs_pkg::WIN_FRAMES)),
    frames_q == tmbs_pkg::CNT_W'($past(frames_q) + 1'b1), "frame count did not advance")

endmodule
